### design/rhc_pkg.sv
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared types and constants for the RGB/HSV pixel converter.
// ----------------------------------------------------------------------------
package rhc_pkg;

    // Default fixed-point formats
    localparam int HUE_FRAC_BITS_DEF = 6;
    localparam int SAT_FRAC_BITS_DEF = 15;

    // Reciprocals for exact floor division of narrow values
    localparam logic [15:0] RECIP15 = 16'd4369;   // 65535 / 15
    localparam logic [15:0] RECIP3  = 16'd21846;  // (65536 + 2) / 3

    // Conversion direction held in the mode register
    typedef enum logic {
        MODE_RGB_TO_HSV = 1'b0,
        MODE_HSV_TO_RGB = 1'b1
    } mode_t;

endpackage

### design/rgb_hsv_converter.sv
// ----------------------------------------------------------------------------
// rgb_hsv_converter
// Pipelined per-pixel converter between RGB and HSV color spaces.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one pixel per request (in_valid / in_stall),
//   the output channel one converted pixel (out_valid / out_stall).
//   cfg_write_en / cfg_write_data load the direction register: 0 turns
//   RGB into HSV, 1 turns HSV into RGB. Write it only while the pipeline
//   is empty; each request samples the mode as it enters.
//   Throughput is one pixel per clock while out_stall is low. The depth of
//   the pipeline is set by the two radix-2 restoring dividers (hue over
//   delta, saturation over max) that resolve one quotient bit per stage.
//   Reset empties the pipeline and selects RGB to HSV.
//   While a result waits under out_stall the whole pipeline holds and
//   in_stall is raised; nothing is dropped or repeated.
//   Hue is degrees * 2^HUE_FRAC_BITS, saturation is Q(SAT_FRAC_BITS).
// ----------------------------------------------------------------------------
module rgb_hsv_converter
    import rhc_pkg::*;
#(
    parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF,
    parameter int SAT_FRAC_BITS = SAT_FRAC_BITS_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic        cfg_write_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_red,
    input  logic [7:0]  in_green,
    input  logic [7:0]  in_blue,
    input  logic [14:0] in_hue,
    input  logic [15:0] in_saturation,
    input  logic [7:0]  in_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue,
    output logic [14:0] out_hue,
    output logic [15:0] out_saturation,
    output logic [7:0]  out_value
);

    localparam int SB         = SAT_FRAC_BITS;
    localparam int SECTOR_LEN = 60 * (1 << HUE_FRAC_BITS);
    localparam int FULL       = 6 * SECTOR_LEN;
    localparam int HW         = $clog2(FULL + 1);
    localparam int WW         = $clog2(SECTOR_LEN + 1);
    localparam int QW         = $clog2((1 << 15) / SECTOR_LEN + 1);
    localparam int ONE        = 1 << SB;
    localparam int SW         = SB + 1;
    localparam int CW         = SB + 8;
    localparam int PW         = CW + WW;
    localparam int NUMW       = PW + 2;
    localparam int YW         = 12;
    localparam int HNW        = $clog2(255 * (4 * SECTOR_LEN + 1) + 1);
    localparam int HQB        = $clog2(2 * SECTOR_LEN + 1);
    localparam int HDDW       = HNW + HQB;
    localparam int SNW        = SB + 10;
    localparam int SQB        = SB + 1;
    localparam int SDDW       = SNW + SQB;
    localparam int K          = (HQB > SQB) ? HQB : SQB;
    localparam int L          = K + 2;

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    logic  adv;
    mode_t cfg_mode_reg;
    logic  valid_reg [1:L];
    mode_t mode_reg  [1:L];

    assign in_stall  = valid_reg[L] && out_stall;
    assign adv       = !in_stall;
    assign out_valid = valid_reg[L];

    // Hold mode register and advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_mode_reg <= MODE_RGB_TO_HSV;
            for (int i = 1; i <= L; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (cfg_write_en)
            begin
                cfg_mode_reg <= mode_t'(cfg_write_data);
            end
            if (adv)
            begin
                valid_reg[1] <= in_valid;
                for (int i = 2; i <= L; i++)
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // Advance mode tags with the data
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mode_reg[1] <= cfg_mode_reg;
            for (int i = 2; i <= L; i++)
            begin
                mode_reg[i] <= mode_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // RGB to HSV: prepare divider operands
    // ------------------------------------------------------------------
    logic [7:0]     mx, mn, dl;
    logic [8:0]     hsum;
    logic [HW-1:0]  base;
    logic [HNW-1:0] hnum;
    logic [SNW-1:0] snum;

    always_comb
    begin
        mx = in_red;
        mn = in_red;
        if (in_green > mx) mx = in_green;
        if (in_blue  > mx) mx = in_blue;
        if (in_green < mn) mn = in_green;
        if (in_blue  < mn) mn = in_blue;
        dl = mx - mn;
        // diff + delta stays non-negative in every sector
        if (mx == in_red)
        begin
            hsum = 9'(in_green) + 9'(dl) - 9'(in_blue);
            base = (in_green < in_blue) ? HW'(FULL) : '0;
        end
        else if (mx == in_green)
        begin
            hsum = 9'(in_blue) + 9'(dl) - 9'(in_red);
            base = HW'(2 * SECTOR_LEN);
        end
        else
        begin
            hsum = 9'(in_red) + 9'(dl) - 9'(in_green);
            base = HW'(4 * SECTOR_LEN);
        end
        hnum = HNW'(hsum) * HNW'(2 * SECTOR_LEN) + HNW'(dl);
        snum = (SNW'(dl) << (SB + 1)) + SNW'(mx);
    end

    // ------------------------------------------------------------------
    // Divider pipelines: one quotient bit per stage
    // ------------------------------------------------------------------
    logic [HNW-1:0] hrem_reg  [1:K+1];
    logic [HQB-1:0] hq_reg    [1:K+1];
    logic [8:0]     hdv_reg   [1:K+1];
    logic [SNW-1:0] srem_reg  [1:K+1];
    logic [SQB-1:0] sq_reg    [1:K+1];
    logic [8:0]     sdv_reg   [1:K+1];
    logic [HW-1:0]  base_reg  [1:K+1];
    logic [7:0]     mx_reg    [1:K+1];
    logic           dz_reg    [1:K+1];
    logic           mz_reg    [1:K+1];

    logic [HNW-1:0] hrem_next [2:K+1];
    logic [HQB-1:0] hq_next   [2:K+1];
    logic [SNW-1:0] srem_next [2:K+1];
    logic [SQB-1:0] sq_next   [2:K+1];
    logic [HDDW-1:0] hsh      [1:K];
    logic [SDDW-1:0] ssh      [1:K];

    // Restoring division steps
    always_comb
    begin
        for (int i = 1; i <= K; i++)
        begin
            hsh[i]         = HDDW'(hdv_reg[i]) << (HQB - i);
            ssh[i]         = SDDW'(sdv_reg[i]) << (SQB - i);
            hrem_next[i+1] = hrem_reg[i];
            hq_next[i+1]   = hq_reg[i];
            srem_next[i+1] = srem_reg[i];
            sq_next[i+1]   = sq_reg[i];
            if (i <= HQB)
            begin
                if (HDDW'(hrem_reg[i]) >= hsh[i])
                begin
                    hrem_next[i+1] = hrem_reg[i] - HNW'(hsh[i]);
                    hq_next[i+1]   = hq_reg[i] | (HQB'(1) << (HQB - i));
                end
            end
            if (i <= SQB)
            begin
                if (SDDW'(srem_reg[i]) >= ssh[i])
                begin
                    srem_next[i+1] = srem_reg[i] - SNW'(ssh[i]);
                    sq_next[i+1]   = sq_reg[i] | (SQB'(1) << (SQB - i));
                end
            end
        end
    end

    // Load and advance divider stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hrem_reg[1] <= hnum;
            hq_reg[1]   <= '0;
            hdv_reg[1]  <= {dl, 1'b0};
            srem_reg[1] <= snum;
            sq_reg[1]   <= '0;
            sdv_reg[1]  <= {mx, 1'b0};
            base_reg[1] <= base;
            mx_reg[1]   <= mx;
            dz_reg[1]   <= (dl == 8'd0);
            mz_reg[1]   <= (mx == 8'd0);
            for (int i = 2; i <= K + 1; i++)
            begin
                hrem_reg[i] <= hrem_next[i];
                hq_reg[i]   <= hq_next[i];
                hdv_reg[i]  <= hdv_reg[i-1];
                srem_reg[i] <= srem_next[i];
                sq_reg[i]   <= sq_next[i];
                sdv_reg[i]  <= sdv_reg[i-1];
                base_reg[i] <= base_reg[i-1];
                mx_reg[i]   <= mx_reg[i-1];
                dz_reg[i]   <= dz_reg[i-1];
                mz_reg[i]   <= mz_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // HSV to RGB: six stages, then a delay line to the output
    // ------------------------------------------------------------------
    logic [QW-1:0]  h1_q_reg,  h1_q_next;
    logic [14:0]    h1_h_reg;
    logic [SW-1:0]  h1_s_reg,  h1_s_next;
    logic [7:0]     h1_v_reg;
    logic [16:0]    s_ext;
    logic [31:0]    q_prod;

    logic [QW-1:0]  h2_q_reg;
    logic [QW-1:0]  h2_q3_reg, h2_q3_next;
    logic [CW-1:0]  h2_c_reg,  h2_c_next;
    logic [WW-1:0]  h2_f_reg,  h2_f_next;
    logic [7:0]     h2_v_reg;
    logic [31:0]    q3_prod;

    logic [2:0]     h3_sec_reg, h3_sec_next;
    logic [WW-1:0]  h3_w_reg,   h3_w_next;
    logic [CW-1:0]  h3_m_reg,   h3_m_next;
    logic [CW-1:0]  h3_c_reg;
    logic [7:0]     h3_v_reg;

    logic [PW-1:0]  h4_p1_reg,  h4_p1_next;
    logic [PW-1:0]  h4_p2_reg,  h4_p2_next;
    logic [7:0]     h4_lo_reg,  h4_lo_next;
    logic [2:0]     h4_sec_reg;
    logic [7:0]     h4_v_reg;

    logic [YW-1:0]  h5_y_reg,   h5_y_next;
    logic [7:0]     h5_lo_reg;
    logic [2:0]     h5_sec_reg;
    logic [7:0]     h5_v_reg;
    logic [NUMW-1:0] num_mid;

    logic [7:0]     mid;
    logic [27:0]    mid_prod;
    logic [23:0]    rgb_next;
    logic [23:0]    rgb_reg [6:L-1];

    // Stage 1: clamp saturation, sector count by reciprocal
    always_comb
    begin
        s_ext     = {1'b0, in_saturation};
        h1_s_next = (s_ext > 17'(ONE)) ? SW'(ONE) : SW'(s_ext);
        q_prod    = (32'(in_hue >> (HUE_FRAC_BITS + 2)) + 32'd1) * 32'(RECIP15);
        h1_q_next = QW'(q_prod >> 16);
    end

    // Stage 2: chroma, position within sector, count over six
    always_comb
    begin
        h2_c_next  = CW'(h1_v_reg) * CW'(h1_s_reg);
        h2_f_next  = WW'(h1_h_reg - 15'(32'(h1_q_reg) * 32'(SECTOR_LEN)));
        q3_prod    = 32'(h1_q_reg >> 1) * 32'(RECIP3);
        h2_q3_next = QW'(q3_prod >> 16);
    end

    // Stage 3: sector, ramp weight, offset m
    always_comb
    begin
        h3_sec_next = 3'(h2_q_reg - QW'(6) * h2_q3_reg);
        h3_w_next   = h2_q_reg[0] ? WW'(SECTOR_LEN) - h2_f_reg : h2_f_reg;
        h3_m_next   = (CW'(h2_v_reg) << SB) - h2_c_reg;
    end

    // Stage 4: products and the lowest channel
    always_comb
    begin
        h4_p1_next = PW'(h3_c_reg) * PW'(h3_w_reg);
        h4_p2_next = PW'(h3_m_reg) * PW'(SECTOR_LEN);
        h4_lo_next = 8'(((CW+1)'(h3_m_reg) + (CW+1)'(1 << (SB - 1))) >> SB);
    end

    // Stage 5: round and scale down to a count of fifteenths
    always_comb
    begin
        num_mid   = ((NUMW'(h4_p1_reg) + NUMW'(h4_p2_reg)) << 1)
                  + (NUMW'(SECTOR_LEN) << SB);
        h5_y_next = YW'(num_mid >> (SB + HUE_FRAC_BITS + 3));
    end

    // Stage 6: divide by fifteen, route channels by sector
    always_comb
    begin
        mid_prod = (28'(h5_y_reg) + 28'd1) * 28'(RECIP15);
        mid      = 8'(mid_prod >> 16);
        case (h5_sec_reg)
            3'd0:    rgb_next = {h5_v_reg, mid, h5_lo_reg};
            3'd1:    rgb_next = {mid, h5_v_reg, h5_lo_reg};
            3'd2:    rgb_next = {h5_lo_reg, h5_v_reg, mid};
            3'd3:    rgb_next = {h5_lo_reg, mid, h5_v_reg};
            3'd4:    rgb_next = {mid, h5_lo_reg, h5_v_reg};
            default: rgb_next = {h5_v_reg, h5_lo_reg, mid};
        endcase
    end

    // Advance HSV to RGB stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h1_q_reg   <= h1_q_next;
            h1_h_reg   <= in_hue;
            h1_s_reg   <= h1_s_next;
            h1_v_reg   <= in_value;
            h2_q_reg   <= h1_q_reg;
            h2_q3_reg  <= h2_q3_next;
            h2_c_reg   <= h2_c_next;
            h2_f_reg   <= h2_f_next;
            h2_v_reg   <= h1_v_reg;
            h3_sec_reg <= h3_sec_next;
            h3_w_reg   <= h3_w_next;
            h3_m_reg   <= h3_m_next;
            h3_c_reg   <= h2_c_reg;
            h3_v_reg   <= h2_v_reg;
            h4_p1_reg  <= h4_p1_next;
            h4_p2_reg  <= h4_p2_next;
            h4_lo_reg  <= h4_lo_next;
            h4_sec_reg <= h3_sec_reg;
            h4_v_reg   <= h3_v_reg;
            h5_y_reg   <= h5_y_next;
            h5_lo_reg  <= h4_lo_reg;
            h5_sec_reg <= h4_sec_reg;
            h5_v_reg   <= h4_v_reg;
            rgb_reg[6] <= rgb_next;
            for (int i = 7; i <= L - 1; i++)
            begin
                rgb_reg[i] <= rgb_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage
    // ------------------------------------------------------------------
    logic [HW:0]   hue_sum, hue_fin;
    logic [7:0]    out_red_next, out_green_next, out_blue_next, out_value_next;
    logic [14:0]   out_hue_next;
    logic [15:0]   out_sat_next;
    logic [7:0]    out_red_reg, out_green_reg, out_blue_reg, out_value_reg;
    logic [14:0]   out_hue_reg;
    logic [15:0]   out_sat_reg;

    // Finish hue and saturation, select fields by mode
    always_comb
    begin
        hue_sum = (HW+1)'(base_reg[K+1]) + (HW+1)'(hq_reg[K+1])
                - (HW+1)'(SECTOR_LEN);
        hue_fin = (hue_sum >= (HW+1)'(FULL)) ? hue_sum - (HW+1)'(FULL) : hue_sum;
        if (dz_reg[K+1])
        begin
            hue_fin = '0;
        end
        out_red_next   = '0;
        out_green_next = '0;
        out_blue_next  = '0;
        out_hue_next   = '0;
        out_sat_next   = '0;
        out_value_next = '0;
        if (mode_reg[L-1] == MODE_HSV_TO_RGB)
        begin
            {out_red_next, out_green_next, out_blue_next} = rgb_reg[L-1];
        end
        else
        begin
            out_hue_next   = 15'(hue_fin);
            out_sat_next   = mz_reg[K+1] ? 16'd0 : 16'(sq_reg[K+1]);
            out_value_next = mx_reg[K+1];
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_red_reg   <= out_red_next;
            out_green_reg <= out_green_next;
            out_blue_reg  <= out_blue_next;
            out_hue_reg   <= out_hue_next;
            out_sat_reg   <= out_sat_next;
            out_value_reg <= out_value_next;
        end
    end

    assign out_red        = out_red_reg;
    assign out_green      = out_green_reg;
    assign out_blue       = out_blue_reg;
    assign out_hue        = out_hue_reg;
    assign out_saturation = out_sat_reg;
    assign out_value      = out_value_reg;

endmodule

### design/rhc_checker.sv
// ----------------------------------------------------------------------------
// rhc_checker
// Port-level checks for the RGB/HSV converter, bound to the top level.
// ----------------------------------------------------------------------------
module rhc_checker
    import rhc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  out_red,
    input logic [7:0]  out_green,
    input logic [7:0]  out_blue,
    input logic [14:0] out_hue,
    input logic [15:0] out_saturation,
    input logic [7:0]  out_value
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped under stall");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_hue) && $stable(out_saturation)
            && $stable(out_value) && $stable(out_red) && $stable(out_green)
            && $stable(out_blue))
        else $error("stalled result changed");

    // Input backpressure comes only from a waiting result
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // Each result carries one color space; the other fields are zero
    a_one_space: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0)
            || (out_hue == 15'd0 && out_saturation == 16'd0 && out_value == 8'd0))
        else $error("both color spaces populated");

endmodule

bind rgb_hsv_converter rhc_checker u_rhc_checker (.*);
